[src/trial_division_factorizer_core_defines.svh]
// Assertion macros for the trial division factoriser.
`ifndef TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off during reset.
`define TDF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdf: same-cycle check failed");
// Next-cycle implication.
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdf: next-cycle check failed");
`else
`define TDF_ASSERT_IMPLIES(lbl, ante, cons)
`define TDF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/tdf_pkg.sv]
package tdf_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned DivW   = 17;  // odd divisors reach 65537
  localparam int unsigned SqW    = 2 * DivW;
  localparam int unsigned ExpW   = 5;
  localparam int unsigned CntW   = $clog2(ValueW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_TWOS,
    ST_ODD_CHECK,
    ST_REDIV,
    ST_DIV_WAIT
  } state_e;

  typedef enum logic [1:0] {
    EK_TWO,
    EK_DIV,
    EK_REST,
    EK_ZERO
  } emit_kind_e;

  typedef struct packed {
    logic       load;
    logic       shift2;
    logic       div_start;
    logic       take_quot;
    logic       next_d;
    logic       emit;
    emit_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic n_odd;
    logic sq_le_n;
    logic div_done;
    logic rem_zero;
    logic e_nonzero;
  } dp_status_t;

endpackage

[src/tdf_divider.sv]
module tdf_divider
  import tdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ValueW-1:0] dividend_i,
  input  logic [DivW-1:0]   divisor_i,   // held stable while running
  output logic              done_o,
  output logic [ValueW-1:0] quotient_o,
  output logic [DivW-1:0]   remainder_o
);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [DivW:0]     trial;
  logic [DivW:0]     diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, quo_q[ValueW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = fits ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[ValueW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ValueW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[src/tdf_datapath.sv]
module tdf_datapath
  import tdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  output logic              result_strobe_o,
  output logic [ValueW-1:0] prime_factor_o,
  output logic [ExpW-1:0]   exponent_o,
  output logic              is_last_o,
  output logic              error_o
);

  logic [ValueW-1:0] n_q, n_d;
  logic [DivW-1:0]   d_q, d_d;
  logic [SqW-1:0]    sq_q, sq_d;
  logic [ExpW-1:0]   e_q, e_d;
  logic              strobe_q;
  logic [ValueW-1:0] prime_q, prime_d;
  logic [ExpW-1:0]   exp_q, exp_d;
  logic              last_q, last_d;
  logic              err_q, err_d;
  logic              div_done;
  logic [ValueW-1:0] quot;
  logic [DivW-1:0]   rem;

  tdf_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (quot),
    .remainder_o (rem)
  );

  always_comb begin
    n_d  = n_q;
    d_d  = d_q;
    sq_d = sq_q;
    e_d  = e_q;
    if (cmd_i.load) begin
      n_d  = value_i;
      d_d  = DivW'(3);
      sq_d = SqW'(9);
      e_d  = '0;
    end else begin
      if (cmd_i.shift2) begin
        n_d = {1'b0, n_q[ValueW-1:1]};
        e_d = e_q + 1'b1;
      end
      if (cmd_i.take_quot) begin
        n_d = quot;
        e_d = e_q + 1'b1;
      end
      if (cmd_i.emit) begin
        e_d = '0;
      end
      if (cmd_i.next_d) begin
        // (d+2)^2 = d^2 + 4d + 4
        d_d  = d_q + DivW'(2);
        sq_d = sq_q + SqW'({d_q, 2'b00}) + SqW'(4);
      end
    end
  end

  always_comb begin
    prime_d = '0;
    exp_d   = '0;
    last_d  = 1'b1;
    err_d   = 1'b0;
    unique case (cmd_i.kind)
      EK_TWO: begin
        prime_d = ValueW'(2);
        exp_d   = e_q;
        last_d  = (n_q == ValueW'(1));
      end
      EK_DIV: begin
        prime_d = ValueW'(d_q);
        exp_d   = e_q;
        last_d  = (n_q == ValueW'(1));
      end
      EK_REST: begin
        prime_d = n_q;
        exp_d   = ExpW'(1);
      end
      EK_ZERO: begin
        err_d = 1'b1;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    d_q  <= d_d;
    sq_q <= sq_d;
    e_q  <= e_d;
    if (cmd_i.emit) begin
      prime_q <= prime_d;
      exp_q   <= exp_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  assign status_o.n_zero    = (n_q == '0);
  assign status_o.n_one     = (n_q == ValueW'(1));
  assign status_o.n_odd     = n_q[0];
  assign status_o.sq_le_n   = (sq_q <= SqW'(n_q));
  assign status_o.div_done  = div_done;
  assign status_o.rem_zero  = (rem == '0);
  assign status_o.e_nonzero = (e_q != '0);

  assign result_strobe_o = strobe_q;
  assign prime_factor_o  = prime_q;
  assign exponent_o      = exp_q;
  assign is_last_o       = last_q;
  assign error_o         = err_q;

endmodule

[src/tdf_ctrl.sv]
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (status_i.n_zero || status_i.n_one) state_d = ST_IDLE;
        else                                   state_d = ST_TWOS;
      end
      ST_TWOS: begin
        if (status_i.n_odd) begin
          state_d = status_i.n_one ? ST_IDLE : ST_ODD_CHECK;
        end
      end
      ST_ODD_CHECK: begin
        state_d = status_i.sq_le_n ? ST_DIV_WAIT : ST_IDLE;
      end
      ST_REDIV: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero)    state_d = ST_REDIV;
          else if (status_i.n_one)  state_d = ST_IDLE;
          else                      state_d = ST_ODD_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_CLASSIFY: begin
        if (status_i.n_zero) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_ZERO;
        end else if (status_i.n_one) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_REST;
        end
      end
      ST_TWOS: begin
        if (!status_i.n_odd) begin
          cmd_o.shift2 = 1'b1;
        end else if (status_i.e_nonzero) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_TWO;
        end
      end
      ST_ODD_CHECK: begin
        if (status_i.sq_le_n) begin
          cmd_o.div_start = 1'b1;
        end else if (!status_i.n_one) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = EK_REST;
        end
      end
      ST_REDIV: begin
        cmd_o.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.take_quot = 1'b1;
          end else begin
            cmd_o.next_d = 1'b1;
            if (status_i.e_nonzero) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = EK_DIV;
            end
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[src/trial_division_factorizer_core.sv]
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          value_i
// result    out        result_strobe_o        prime_factor_o, exponent_o, is_last_o, error_o
//
// Sequence: zero and one put their single beat on the ports from the classify
// state through the result register. Powers of two are stripped one factor of
// 2 per step. Each odd trial divisor takes a square check, a bit-serial divide
// and a decision, plus another divide and decision per power found, so a prime
// near 2^32 is tried against every odd divisor below 2^16.
// Reset: asynchronous, active low; clears the controller, divider sequencing
// and the result strobe. No clearing pass.
// Stalls: none; busy is high from the cycle after acceptance until the last
// beat is registered, is already low while that beat is shown, and the
// receiver takes every beat as shown.
`include "trial_division_factorizer_core_defines.svh"

module trial_division_factorizer_core
  import tdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value_i,
  output logic              result_strobe_o,
  output logic [ValueW-1:0] prime_factor_o,
  output logic [ExpW-1:0]   exponent_o,
  output logic              is_last_o,
  output logic              error_o
);

  // Controller sequences: classify -> strip twos -> odd divisor loop -> leftover.
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       err_beat_clear;

  tdf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Datapath holds remainder n, divisor d, d^2 kept by increments, the
  // running exponent, the divider and the registered result beat.
  tdf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_strobe_o (result_strobe_o),
    .prime_factor_o  (prime_factor_o),
    .exponent_o      (exponent_o),
    .is_last_o       (is_last_o),
    .error_o         (error_o)
  );

  assign err_beat_clear = is_last_o && (prime_factor_o == '0) && (exponent_o == '0);

  // An error beat is the lone, last beat with zero payload.
  `TDF_ASSERT_IMPLIES(a_err_beat, result_strobe_o && error_o, err_beat_clear)
  // Normal beats always carry a nonzero exponent.
  `TDF_ASSERT_IMPLIES(a_exp_nonzero, result_strobe_o && !error_o, exponent_o != '0)
  // The last beat of a number leaves with the core already idle.
  `TDF_ASSERT_IMPLIES(a_idle_on_last, result_strobe_o && is_last_o, !busy)
  // An accepted number keeps the core busy next cycle.
  `TDF_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
  import tdf_pkg::*;
();

  // Directed numbers first, then built random numbers.
  localparam int unsigned DirRows   = 19;
  localparam int unsigned RandItems = 81;
  localparam int unsigned MaxGap    = 12;
  // Drain allowance after the last beat, in cycles.
  localparam int unsigned DrainCycles = 64;

  localparam logic [ValueW-1:0] SmallestPrime = 2;

  // One result beat as it appears on the result ports.
  typedef struct packed {
    logic [ValueW-1:0] prime;
    logic [ExpW-1:0]   expo;
    logic              last;
    logic              err;
  } factor_beat_t;

  // A directed row. Where typed is set, the number gives exactly one beat,
  // written out below; otherwise the predictor works the beats out.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              typed;
    factor_beat_t      beat;
  } factor_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [ValueW-1:0] value_i;
  logic              result_strobe_o;
  logic [ValueW-1:0] prime_factor_o;
  logic [ExpW-1:0]   exponent_o;
  logic              is_last_o;
  logic              error_o;

  // Beats still owed by the block, oldest first.
  factor_beat_t pending_factors[$];
  factor_beat_t want_beat;
  factor_row_t  dir_rows [DirRows];

  int unsigned err_count     = 0;
  int unsigned beats_checked = 0;
  int unsigned error_beats   = 0;
  int unsigned values_sent   = 0;
  // Set for runs of back-to-back commands with no idle gap.
  bit          eager = 1'b0;

  trial_division_factorizer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .value_i         (value_i),
    .result_strobe_o (result_strobe_o),
    .prime_factor_o  (prime_factor_o),
    .exponent_o      (exponent_o),
    .is_last_o       (is_last_o),
    .error_o         (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic factor_beat_t mk_beat(input logic [ValueW-1:0] p,
                                           input logic [ExpW-1:0] e,
                                           input logic last, input logic err);
    factor_beat_t b;
    b.prime = p;
    b.expo  = e;
    b.last  = last;
    b.err   = err;
    return b;
  endfunction

  // Factorisation predictor: queues the beats one number must produce.
  task automatic predict_factors(input logic [ValueW-1:0] num);
    logic [ValueW-1:0] rest;
    logic [ValueW-1:0] div;
    logic [ExpW-1:0]   pw;
    if (num == '0) begin
      // zero cannot be factored: a lone error beat
      pending_factors.push_back(mk_beat('0, '0, 1'b1, 1'b1));
    end else if (num == 1) begin
      // one reports itself with power one
      pending_factors.push_back(mk_beat(1, 1, 1'b1, 1'b0));
    end else begin
      rest = num;
      pw   = '0;
      // strip the twos first
      while (rest % SmallestPrime == 0) begin
        rest = rest / SmallestPrime;
        pw++;
      end
      if (pw != '0) pending_factors.push_back(mk_beat(SmallestPrime, pw, rest == 1, 1'b0));
      // odd divisors while div^2 <= rest; 64-bit compare avoids wrap
      div = 3;
      while ({32'b0, div} * {32'b0, div} <= {32'b0, rest}) begin
        if (rest % div == 0) begin
          pw = '0;
          while (rest % div == 0) begin
            rest = rest / div;
            pw++;
          end
          pending_factors.push_back(mk_beat(div, pw, rest == 1, 1'b0));
        end
        div += 2;
      end
      // whatever survives is a prime above the last divisor tried
      if (rest > 1) pending_factors.push_back(mk_beat(rest, 1, 1'b1, 1'b0));
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    err_count++;
  endtask

  // Present one number and hold it until the block takes it. The gap is drawn
  // per number; in eager stretches the next command follows straight on.
  task automatic send_value(input logic [ValueW-1:0] num);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= num;
    // values read here are those the block saw at this edge
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_factors(num);
    values_sent++;
  endtask

  // Result monitor: every strobe must match the oldest owed beat.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_factors.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing owed: factor %0d exp %0d",
                                prime_factor_o, exponent_o));
      end else begin
        want_beat = pending_factors.pop_front();
        if (prime_factor_o !== want_beat.prime)
          flag_mismatch($sformatf("prime_factor %0d, want %0d",
                                  prime_factor_o, want_beat.prime));
        if (exponent_o !== want_beat.expo)
          flag_mismatch($sformatf("exponent %0d for factor %0d, want %0d",
                                  exponent_o, want_beat.prime, want_beat.expo));
        if (is_last_o !== want_beat.last)
          flag_mismatch($sformatf("is_last %b for factor %0d, want %b",
                                  is_last_o, want_beat.prime, want_beat.last));
        if (error_o !== want_beat.err)
          flag_mismatch($sformatf("error %b for factor %0d, want %b",
                                  error_o, want_beat.prime, want_beat.err));
        beats_checked++;
        if (want_beat.err) error_beats++;
      end
    end
  end

  initial begin
    longint unsigned num;
    int unsigned     f;
    int unsigned     sel;

    rst_ni  <= 1'b0;
    start   <= 1'b0;
    value_i <= '0;

    dir_rows = '{
      // zero: error beat
      '{32'd0,          1'b1, '{32'd0,          5'd0,  1'b1, 1'b1}},
      // one: reported as itself
      '{32'd1,          1'b1, '{32'd1,          5'd1,  1'b1, 1'b0}},
      // smallest primes and the first power of two
      '{32'd2,          1'b1, '{32'd2,          5'd1,  1'b1, 1'b0}},
      '{32'd3,          1'b1, '{32'd3,          5'd1,  1'b1, 1'b0}},
      '{32'd4,          1'b1, '{32'd2,          5'd2,  1'b1, 1'b0}},
      // top bit alone: largest exponent
      '{32'h8000_0000,  1'b1, '{32'd2,          5'd31, 1'b1, 1'b0}},
      // all ones: 3*5*17*257*65537
      '{32'hFFFF_FFFF,  1'b0, '0},
      '{32'd6,          1'b0, '0},
      '{32'd9,          1'b0, '0},
      '{32'd12,         1'b0, '0},
      '{32'd25,         1'b0, '0},
      '{32'd343,        1'b0, '0},
      // first nine primes multiplied: the most beats a number can give
      '{32'd223092870,  1'b0, '0},
      // 3^20: large exponent of an odd divisor
      '{32'd3486784401, 1'b0, '0},
      // prime just above 2^16, so beyond any trial divisor squared test
      '{32'd65537,      1'b1, '{32'd65537,      5'd1,  1'b1, 1'b0}},
      // 65535^2: squared factors near the top of the range
      '{32'd4294836225, 1'b0, '0},
      // twos or a three, then a large leftover prime
      '{32'd4096012288, 1'b0, '0},
      '{32'd3000009,    1'b0, '0},
      // largest 32-bit prime: as slow as any number there is
      '{32'd4294967291, 1'b1, '{32'd4294967291, 5'd1,  1'b1, 1'b0}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Typed rows replace the predicted beat with the written one.
    for (int i = 0; i < DirRows; i++) begin
      eager = (i % 7) < 2;
      send_value(dir_rows[i].value);
      if (dir_rows[i].typed) begin
        void'(pending_factors.pop_back());
        pending_factors.push_back(dir_rows[i].beat);
      end
    end

    // Random part. Numbers are built from small factors and a bounded tail so
    // the block's trial loop stays short; a few tails reach 2^20 - 1.
    for (int i = 0; i < RandItems; i++) begin
      eager = (i % 20) < 5;
      sel   = $urandom_range(0, 9);
      if (sel == 0) begin
        num = $urandom_range(0, 64);
      end else begin
        num = $urandom_range(1, (sel > 7) ? 32'h000F_FFFF : 32'h0000_FFFF);
        repeat ($urandom_range(0, 6)) begin
          f = $urandom_range(2, 255);
          if (num * f <= 64'hFFFF_FFFF) num = num * f;
        end
      end
      send_value(num[ValueW-1:0]);
    end
    start <= 1'b0;

    // Wait for every owed beat, then give the block time to misbehave.
    while (pending_factors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Factorised %0d numbers (%0d directed, %0d random).",
             values_sent, DirRows, RandItems);
    $display("Checked %0d factor beats, %0d of them error beats.",
             beats_checked, error_beats);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: the largest prime alone tries every odd divisor below 2^16.
  initial begin
    #80_000_000;
    $display("Timed out with %0d beats still owed.", pending_factors.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/tdf_pkg.sv
src/tdf_divider.sv
src/tdf_datapath.sv
src/tdf_ctrl.sv
src/trial_division_factorizer_core.sv
bench/tb_top.sv
